// File: hw/rtl/sccr_pkg.sv
`default_nettype none
package sccr_pkg;

  localparam int unsigned FRAMES    = 16;
  localparam int unsigned PAGE_BITS = 16;
  localparam int unsigned FRAME_W   = $clog2(FRAMES);
  localparam int unsigned FCNT_W    = $clog2(FRAMES + 1);
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned PAGE_W    = 16;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;

  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

  // Register indexes on the configuration port.
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWEEP
  } sccr_state_e;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_NEXT,
    CMD_HIT,
    CMD_SWEEP_START,
    CMD_SWEEP_STEP,
    CMD_MISS
  } sccr_cmd_e;

  typedef struct packed {
    logic match;
    logic last;
    logic ref_set;
    logic out_free;
  } sccr_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/sccr_req_if.sv
`default_nettype none
interface sccr_req_if;
  logic                             valid;
  logic                             ready;
  logic [sccr_pkg::PAGE_W-1:0]      page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sccr_rsp_if.sv
`default_nettype none
interface sccr_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             is_fault;
  logic                             victim_valid;
  logic [sccr_pkg::PAGE_W-1:0]      victim_page;
  logic [sccr_pkg::SLOT_W-1:0]      frame_slot;
  logic [sccr_pkg::COUNT_W-1:0]     fault_total;

  modport source (output valid, output is_fault, output victim_valid, output victim_page,
                  output frame_slot, output fault_total, input ready);
  modport sink   (input valid, input is_fault, input victim_valid, input victim_page,
                  input frame_slot, input fault_total, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sccr_ctrl.sv
`default_nettype none
module sccr_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  sccr_pkg::sccr_status_t status_i,
  output sccr_pkg::sccr_cmd_e    cmd_o
);

  sccr_pkg::sccr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sccr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = sccr_pkg::CMD_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      sccr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = sccr_pkg::CMD_LOAD;
          state_d = sccr_pkg::ST_SEARCH;
        end
      end
      sccr_pkg::ST_SEARCH: begin
        // A hit waits in place until the output register can take the result.
        priority if (status_i.match) begin
          if (status_i.out_free) begin
            cmd_o   = sccr_pkg::CMD_HIT;
            state_d = sccr_pkg::ST_IDLE;
          end
        end else if (status_i.last) begin
          cmd_o   = sccr_pkg::CMD_SWEEP_START;
          state_d = sccr_pkg::ST_SWEEP;
        end else begin
          cmd_o = sccr_pkg::CMD_NEXT;
        end
      end
      sccr_pkg::ST_SWEEP: begin
        priority if (status_i.ref_set) begin
          cmd_o = sccr_pkg::CMD_SWEEP_STEP;
        end else if (status_i.out_free) begin
          cmd_o   = sccr_pkg::CMD_MISS;
          state_d = sccr_pkg::ST_IDLE;
        end else begin
          cmd_o = sccr_pkg::CMD_NOP;
        end
      end
      default: begin
        state_d = sccr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/sccr_dp.sv
`default_nettype none
module sccr_dp (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire  [sccr_pkg::CFG_W-1:0]          frames_in_use_i,
  input  wire  [sccr_pkg::PAGE_W-1:0]         page_number_i,
  input  sccr_pkg::sccr_cmd_e                 cmd_i,
  output sccr_pkg::sccr_status_t              status_o,
  sccr_rsp_if.source                          rsp
);

  logic [sccr_pkg::PAGE_BITS-1:0] frame_page_q [sccr_pkg::FRAMES];
  logic [sccr_pkg::FRAMES-1:0]    valid_q;
  logic [sccr_pkg::FRAMES-1:0]    ref_q;
  logic [sccr_pkg::FRAME_W-1:0]   hand_q;
  logic [sccr_pkg::COUNT_W-1:0]   count_q;
  logic [sccr_pkg::FRAME_W-1:0]   scan_q;
  logic [sccr_pkg::PAGE_BITS-1:0] page_q;

  logic                           out_valid_q;
  logic                           out_valid_d;
  logic                           out_fault_q;
  logic                           out_victim_valid_q;
  logic [sccr_pkg::PAGE_W-1:0]    out_victim_page_q;
  logic [sccr_pkg::SLOT_W-1:0]    out_slot_q;
  logic [sccr_pkg::COUNT_W-1:0]   out_total_q;

  logic [sccr_pkg::FCNT_W-1:0]    active;
  logic [sccr_pkg::FRAME_W-1:0]   last_idx;
  logic [sccr_pkg::FRAME_W-1:0]   scan_next;
  logic [sccr_pkg::FRAME_W-1:0]   sweep_start;
  logic [sccr_pkg::COUNT_W-1:0]   count_inc;
  logic [sccr_pkg::PAGE_BITS-1:0] cur_page;
  logic                           cur_valid;

  // Zero frames act as one, more than built act as all of them.
  always_comb begin
    priority if (frames_in_use_i == '0) begin
      active = sccr_pkg::FCNT_W'(1);
    end else if (sccr_pkg::FCNT_W'(frames_in_use_i) > sccr_pkg::FCNT_W'(sccr_pkg::FRAMES)) begin
      active = sccr_pkg::FCNT_W'(sccr_pkg::FRAMES);
    end else begin
      active = sccr_pkg::FCNT_W'(frames_in_use_i);
    end
  end

  assign last_idx    = sccr_pkg::FRAME_W'(active - sccr_pkg::FCNT_W'(1));
  assign scan_next   = (scan_q == last_idx) ? '0 : scan_q + sccr_pkg::FRAME_W'(1);
  // A hand left beyond a shrunken frame count restarts at frame zero.
  assign sweep_start = (sccr_pkg::FCNT_W'(hand_q) >= active) ? '0 : hand_q;
  assign count_inc   = (count_q == '1) ? count_q : count_q + sccr_pkg::COUNT_W'(1);
  assign cur_page    = frame_page_q[scan_q];
  assign cur_valid   = valid_q[scan_q];

  assign status_o.match    = cur_valid && (cur_page == page_q);
  assign status_o.last     = (scan_q == last_idx);
  assign status_o.ref_set  = ref_q[scan_q];
  assign status_o.out_free = !out_valid_q || rsp.ready;

  // A new result may be loaded in the same cycle as the waiting one is taken.
  always_comb begin
    priority if (cmd_i == sccr_pkg::CMD_HIT || cmd_i == sccr_pkg::CMD_MISS) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && rsp.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      ref_q       <= '0;
      hand_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (cmd_i)
        sccr_pkg::CMD_HIT: begin
          ref_q[scan_q] <= 1'b1;
        end
        sccr_pkg::CMD_SWEEP_STEP: begin
          ref_q[scan_q] <= 1'b0;
        end
        sccr_pkg::CMD_MISS: begin
          valid_q[scan_q] <= 1'b1;
          ref_q[scan_q]   <= 1'b0;
          hand_q          <= scan_next;
          count_q         <= count_inc;
        end
        sccr_pkg::CMD_NOP, sccr_pkg::CMD_LOAD, sccr_pkg::CMD_NEXT,
        sccr_pkg::CMD_SWEEP_START: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      sccr_pkg::CMD_LOAD: begin
        page_q <= sccr_pkg::PAGE_BITS'(page_number_i);
        scan_q <= '0;
      end
      sccr_pkg::CMD_NEXT: begin
        scan_q <= scan_q + sccr_pkg::FRAME_W'(1);
      end
      sccr_pkg::CMD_SWEEP_START: begin
        scan_q <= sweep_start;
      end
      sccr_pkg::CMD_SWEEP_STEP: begin
        scan_q <= scan_next;
      end
      sccr_pkg::CMD_HIT: begin
        out_fault_q        <= 1'b0;
        out_victim_valid_q <= 1'b0;
        out_victim_page_q  <= '0;
        out_slot_q         <= sccr_pkg::SLOT_W'(scan_q);
        out_total_q        <= count_q;
      end
      sccr_pkg::CMD_MISS: begin
        frame_page_q[scan_q] <= page_q;
        out_fault_q          <= 1'b1;
        out_victim_valid_q   <= cur_valid;
        out_victim_page_q    <= cur_valid ? sccr_pkg::PAGE_W'(cur_page) : '0;
        out_slot_q           <= sccr_pkg::SLOT_W'(scan_q);
        out_total_q          <= count_inc;
      end
      sccr_pkg::CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.is_fault     = out_fault_q;
  assign rsp.victim_valid = out_victim_valid_q;
  assign rsp.victim_page  = out_victim_page_q;
  assign rsp.frame_slot   = out_slot_q;
  assign rsp.fault_total  = out_total_q;

endmodule
`default_nettype wire

// File: hw/rtl/second_chance_clock_replacement_top.sv
`default_nettype none
// Second-chance (clock) page replacement over up to 16 frames.
// req_i carries one page reference per item; rsp_o returns exactly one result
// item per reference: fault flag, evicted page if any, the frame now holding
// the page and the saturating fault count. Both use valid/ready handshakes.
// The hit search checks one frame per cycle, up to the active frame count,
// and on a miss the hand then tests one frame per cycle, clearing set
// reference bits, for at most the active frame count plus one frames. The
// frame table is a register file read through a single index, which is why
// frames are tested one at a time. One item is worked on at a time; the next
// is taken as soon as the previous result sits in the output register, even
// if the receiver has not taken it. If the receiver stalls, a finished result
// waits in the block and no new result overwrites it. Reset empties all
// frames, clears reference bits, the hand and the fault count, and sets
// frames_in_use to 16. frames_in_use is written over the APB port at address
// 0; the user must write it only while the block is idle, as the block itself
// does not enforce this.
module second_chance_clock_replacement_top (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  sccr_req_if.sink                          req_i,
  sccr_rsp_if.source                        rsp_o,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [sccr_pkg::APB_AW-1:0]       paddr,
  input  wire  [sccr_pkg::APB_DW-1:0]       pwdata,
  output logic [sccr_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  logic [sccr_pkg::CFG_W-1:0] frames_q;
  sccr_pkg::sccr_cmd_e        cmd;
  sccr_pkg::sccr_status_t     status;
  logic                       reg_sel;

  assign reg_sel = (paddr[sccr_pkg::APB_AW-1] == sccr_pkg::REG_FRAMES_IN_USE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? sccr_pkg::APB_DW'(frames_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= sccr_pkg::FRAMES_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      frames_q <= pwdata[sccr_pkg::CFG_W-1:0];
    end
  end

  sccr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sccr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frames_in_use_i (frames_q),
    .page_number_i   (req_i.page_number),
    .cmd_i           (cmd),
    .status_o        (status),
    .rsp             (rsp_o)
  );

endmodule
`default_nettype wire
